// File: rtl/spq_pkg.sv
package spq_pkg;

  localparam int DEPTH         = 16;
  localparam int KEY_WIDTH     = 16;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int CNT_WIDTH     = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef logic [KEY_WIDTH-1:0]     key_t;
  typedef logic [PAYLOAD_WIDTH-1:0] payload_t;
  typedef logic [CNT_WIDTH-1:0]     count_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ctrl_t;

endpackage

// File: rtl/spq_in_if.sv
interface spq_in_if;
  logic              valid;
  logic              ready;
  logic              action;
  spq_pkg::key_t     new_key;
  spq_pkg::payload_t new_payload;

  modport source (output valid, output action, output new_key, output new_payload,
                  input ready);
  modport sink (input valid, input action, input new_key, input new_payload,
                output ready);
endinterface

// File: rtl/spq_out_if.sv
interface spq_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  spq_pkg::key_t     popped_key;
  spq_pkg::payload_t popped_payload;
  logic              is_empty;
  spq_pkg::key_t     head_key;
  spq_pkg::count_t   entry_count;

  modport source (output valid, output status, output popped_key, output popped_payload,
                  output is_empty, output head_key, output entry_count, input ready);
  modport sink (input valid, input status, input popped_key, input popped_payload,
                input is_empty, input head_key, input entry_count, output ready);
endinterface

// File: rtl/spq_cell.sv
module spq_cell (
  input  logic              clk,
  input  spq_pkg::ctrl_t    ctrl,
  input  logic              live,
  input  spq_pkg::key_t     new_key,
  input  spq_pkg::payload_t new_payload,
  input  logic              prev_ins,
  input  spq_pkg::key_t     prev_key,
  input  spq_pkg::payload_t prev_payload,
  input  spq_pkg::key_t     next_key,
  input  spq_pkg::payload_t next_payload,
  output logic              ins,
  output spq_pkg::key_t     key,
  output spq_pkg::payload_t payload,
  output spq_pkg::key_t     key_next
);

  spq_pkg::payload_t payload_next;

  // new entry lands at or before this slot
  assign ins = !live || (key > new_key);

  always_comb begin
    key_next     = key;
    payload_next = payload;
    if (ctrl.push && ins) begin
      if (prev_ins) begin
        key_next     = prev_key;
        payload_next = prev_payload;
      end else begin
        key_next     = new_key;
        payload_next = new_payload;
      end
    end else if (ctrl.pop) begin
      key_next     = next_key;
      payload_next = next_payload;
    end
  end

  always_ff @(posedge clk) begin
    key     <= key_next;
    payload <= payload_next;
  end

endmodule

// File: rtl/sorted_priority_queue.sv
// the result is held in an output register and is valid in the cycle after its input transfer
// throughput: one push or pop per cycle, the cells that shift all move in the same cycle
// a new item is taken only when the output register is empty or its result transfers
// in the same cycle, so a stalled output holds the input
// reset: synchronous, clears the entry count and the output valid; cell contents
// are not cleared and only slots below the count ever affect a result
module sorted_priority_queue (
  input logic      clk,
  input logic      rst,
  spq_in_if.sink   in_ch,
  spq_out_if.source out_ch
);

  localparam int N = spq_pkg::DEPTH;

  spq_pkg::count_t   count;
  spq_pkg::count_t   count_next;
  spq_pkg::ctrl_t    ctrl;
  logic              accept;
  logic              full;
  logic              empty;
  logic              out_valid;

  logic              ins      [N];
  logic              live     [N];
  spq_pkg::key_t     keys     [N];
  spq_pkg::payload_t payloads [N];
  spq_pkg::key_t     keys_next[N];

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count == spq_pkg::CNT_WIDTH'(N));
  assign empty       = (count == '0);
  assign ctrl.push   = accept && (in_ch.action == spq_pkg::ACT_PUSH) && !full;
  assign ctrl.pop    = accept && (in_ch.action == spq_pkg::ACT_POP) && !empty;

  always_comb begin
    count_next = count;
    if (ctrl.push) begin
      count_next = count + 1'b1;
    end else if (ctrl.pop) begin
      count_next = count - 1'b1;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign live[i] = (spq_pkg::CNT_WIDTH'(i) < count);
    if (i == 0) begin : g_first
      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .live        (live[i]),
        .new_key     (in_ch.new_key),
        .new_payload (in_ch.new_payload),
        .prev_ins    (1'b0),
        .prev_key    (in_ch.new_key),
        .prev_payload(in_ch.new_payload),
        .next_key    (keys[(i + 1) % N]),
        .next_payload(payloads[(i + 1) % N]),
        .ins         (ins[i]),
        .key         (keys[i]),
        .payload     (payloads[i]),
        .key_next    (keys_next[i])
      );
    end else if (i == N - 1) begin : g_last
      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .live        (live[i]),
        .new_key     (in_ch.new_key),
        .new_payload (in_ch.new_payload),
        .prev_ins    (ins[i - 1]),
        .prev_key    (keys[i - 1]),
        .prev_payload(payloads[i - 1]),
        .next_key    (keys[i]),
        .next_payload(payloads[i]),
        .ins         (ins[i]),
        .key         (keys[i]),
        .payload     (payloads[i]),
        .key_next    (keys_next[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .live        (live[i]),
        .new_key     (in_ch.new_key),
        .new_payload (in_ch.new_payload),
        .prev_ins    (ins[i - 1]),
        .prev_key    (keys[i - 1]),
        .prev_payload(payloads[i - 1]),
        .next_key    (keys[i + 1]),
        .next_payload(payloads[i + 1]),
        .ins         (ins[i]),
        .key         (keys[i]),
        .payload     (payloads[i]),
        .key_next    (keys_next[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_ch.action == spq_pkg::ACT_PUSH) begin
        out_ch.status <= full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
      end else begin
        out_ch.status <= empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
      end
      out_ch.popped_key     <= ctrl.pop ? keys[0] : '0;
      out_ch.popped_payload <= ctrl.pop ? payloads[0] : '0;
      out_ch.is_empty       <= (count_next == '0);
      out_ch.head_key       <= (count_next == '0) ? '0 : keys_next[0];
      out_ch.entry_count    <= count_next;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

// File: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [1:0] status;
    key_t       popped_key;
    payload_t   popped_payload;
    logic       is_empty;
    key_t       head_key;
    count_t     entry_count;
  } queue_result_t;

  class queue_scoreboard;
    key_t          keys[DEPTH];
    payload_t      payloads[DEPTH];
    int            fill;
    queue_result_t pending[$];
    int unsigned   errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    // ordered insert or head removal, then the expected status of the queue
    function void note_request(logic act, key_t k, payload_t p);
      queue_result_t r;
      int pos;
      int i;
      r = '0;
      r.status = ST_OK;
      if (act == ACT_PUSH) begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < fill && keys[pos] <= k) pos++;
          for (i = fill; i > pos; i--) begin
            keys[i] = keys[i-1];
            payloads[i] = payloads[i-1];
          end
          keys[pos] = k;
          payloads[pos] = p;
          fill++;
        end
      end else begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_key = keys[0];
          r.popped_payload = payloads[0];
          for (i = 1; i < fill; i++) begin
            keys[i-1] = keys[i];
            payloads[i-1] = payloads[i];
          end
          fill--;
        end
      end
      r.is_empty = (fill == 0);
      r.head_key = (fill == 0) ? key_t'(0) : keys[0];
      r.entry_count = count_t'(fill);
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("popped_key", 32'(want.popped_key), 32'(got.popped_key));
      compare_field("popped_payload", 32'(want.popped_payload), 32'(got.popped_payload));
      compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
      compare_field("head_key", 32'(want.head_key), 32'(got.head_key));
      compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   sender_no_gaps = 1'b0;
  int unsigned idle_cycles = 0;

  queue_scoreboard sb = new();

  spq_in_if  in_ch();
  spq_out_if out_ch();

  sorted_priority_queue u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: timeout", $time);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_request(input logic act, input key_t k, input payload_t p);
    int unsigned gap;
    gap = sender_no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.action = act;
    in_ch.new_key = k;
    in_ch.new_payload = p;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(act, k, p);
    @(negedge clk);
  endtask

  task automatic wait_until_drained();
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // segments with a push or pop bias so that the queue swings between empty and full
  task automatic run_random(int unsigned total);
    int unsigned sent;
    int unsigned seg_len;
    int unsigned push_pct;
    int unsigned key_mode;
    logic act;
    key_t k;
    sent = 0;
    while (sent < total) begin
      seg_len = $urandom_range(10, 60);
      case ($urandom_range(0, 3))
        0: push_pct = 85;
        1: push_pct = 15;
        2: push_pct = 50;
        default: push_pct = 60;
      endcase
      key_mode = $urandom_range(0, 3);
      sender_no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < seg_len && sent < total; n++) begin
        act = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
        case (key_mode)
          0: k = key_t'($urandom);
          1: k = key_t'($urandom_range(0, 7));
          2: k = $urandom_range(0, 1) ? key_t'('1) : key_t'(0);
          default: k = key_t'($urandom_range(0, 3) == 0 ? 0 : $urandom);
        endcase
        send_request(act, k, payload_t'($urandom));
        sent++;
      end
    end
    sender_no_gaps = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_PUSH;
    in_ch.new_key = '0;
    in_ch.new_payload = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // underflow, extremes, equal keys, fill up, overflow, ordered removal
    send_request(ACT_POP, '0, '0);
    send_request(ACT_PUSH, '0, '0);
    send_request(ACT_PUSH, '1, '1);
    send_request(ACT_PUSH, key_t'(5), payload_t'(32'hA));
    send_request(ACT_PUSH, key_t'(5), payload_t'(32'hB));
    send_request(ACT_PUSH, key_t'(5), payload_t'(32'hC));
    for (int n = 0; n < DEPTH - 5; n++) begin
      send_request(ACT_PUSH, key_t'($urandom), payload_t'($urandom));
    end
    send_request(ACT_PUSH, key_t'(1), payload_t'(32'h1));
    repeat (4) send_request(ACT_POP, '0, '0);
    wait_until_drained();

    run_random(900);
    wait_until_drained();
    run_random(980);

    wait_until_drained();
    repeat (4) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    int unsigned stall_free;
    queue_result_t got;
    stall_free = 0;
    out_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (stall_free == 0 && $urandom_range(0, 3) == 0) stall_free = $urandom_range(5, 40);
      if (stall_free > 0) begin
        gap = 0;
        stall_free--;
      end else begin
        gap = $urandom_range(0, 16);
      end
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.status = out_ch.status;
      got.popped_key = out_ch.popped_key;
      got.popped_payload = out_ch.popped_payload;
      got.is_empty = out_ch.is_empty;
      got.head_key = out_ch.head_key;
      got.entry_count = out_ch.entry_count;
      sb.check_result(got);
      @(negedge clk);
    end
  end

endmodule
